FILE: rtl/core/lfpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types and constants of the line-follow PID drive
// Holds the configuration record, the queued command item, the back-end
// sequencer states and the fixed constants of the drive law.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    localparam int SENSOR_W = 8;
    localparam int GAIN_W   = 8;
    localparam int POS_W    = 4;
    localparam int ERR_W    = 5;
    localparam int ACC_W    = 16;
    localparam int DUTY_W   = 10;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_SPEED = 3'd4;

    // Register reset values.
    localparam logic [GAIN_W-1:0] KP_RESET  = 8'd10;
    localparam logic [GAIN_W-1:0] KI_RESET  = 8'd0;
    localparam logic [GAIN_W-1:0] KD_RESET  = 8'd5;
    localparam logic [GAIN_W-1:0] MAX_RESET = 8'd255;
    localparam logic [GAIN_W-1:0] MIN_RESET = 8'd0;

    // Recovery turn duties applied when the line is lost.
    localparam logic [DUTY_W-1:0] LOST_LEFT_LDUTY  = 10'd150;
    localparam logic [DUTY_W-1:0] LOST_LEFT_RDUTY  = 10'd185;
    localparam logic [DUTY_W-1:0] LOST_RIGHT_LDUTY = 10'd180;
    localparam logic [DUTY_W-1:0] LOST_RIGHT_RDUTY = 10'd155;

    // Drive law constants.
    localparam logic signed [ACC_W-1:0] LEFT_TRIM  = 16'sd5;
    localparam logic signed [ACC_W-1:0] TURN_BIAS  = 16'sd15;
    localparam logic signed [6:0]       STEP_BIAS  = 7'sd20;
    localparam logic [15:0]             DIV10_RECIP = 16'd52429;
    localparam int                      DIV10_SHIFT = 19;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_gain;
        logic [GAIN_W-1:0] kd_gain;
        logic [GAIN_W-1:0] top_speed;
        logic [GAIN_W-1:0] floor_speed;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_PID,
        CMD_LOST_LEFT,
        CMD_LOST_RIGHT
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [POS_W-1:0] position;
        logic             left_rev;
        logic             right_rev;
    } item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PROD,
        BK_DIV_I,
        BK_DIV_P,
        BK_DIV_D,
        BK_MUL,
        BK_DUTY
    } back_state_t;

endpackage

FILE: rtl/core/line_follow_pid_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pid_drive: PID line follower motor drive
// Turns each line-sensor sample into two motor duties and direction bits.
// ----------------------------------------------------------------------------
// Usage. Each item on the s_ channel is one 8-bit active-low sensor sample;
// each item on the m_ channel is the drive result for that sample, one result
// per sample, in order. Both channels use valid/ready and move an item when
// both are high at a rising edge of aclk.
// A PID sample passes from the queue through BK_PROD, BK_DIV_I, BK_DIV_P,
// BK_DIV_D, BK_MUL and BK_DUTY into the output register; a recovery sample
// goes from BK_IDLE straight to BK_DUTY. The back end works on one item at
// a time; its sequencer walks the gain products, one shared divide-by-ten
// unit over three operands, the step products and the duty clamp, one step
// per cycle, but BK_DUTY waits while the output register holds a result.
// A two-entry queue lets the front keep accepting samples while a result
// waits there; when m_ready stays low the queue fills and s_ready drops.
// The user must write the gains and speed limits (cfg_wr_en, cfg_index,
// cfg_wdata) only while the block is idle; the block does not enforce it.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// the position, integral, previous error and both reverse bits, and empties
// the queue and the output register.
// ----------------------------------------------------------------------------
module line_follow_pid_drive (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lfpd_pkg::GAIN_W-1:0]           cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [lfpd_pkg::SENSOR_W-1:0]         s_sensor_bits,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [lfpd_pkg::DUTY_W-1:0]    m_left_duty,
    output logic signed [lfpd_pkg::DUTY_W-1:0]    m_right_duty,
    output logic                                  m_left_reverse,
    output logic                                  m_right_reverse,
    output logic                                  m_line_lost,
    output logic signed [lfpd_pkg::POS_W-1:0]     m_line_position
);
    import lfpd_pkg::*;

    // Configuration registers. Writes to unused indexes are ignored.
    cfg_t  cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_gain     <= KP_RESET;
            cfg_reg.ki_gain     <= KI_RESET;
            cfg_reg.kd_gain     <= KD_RESET;
            cfg_reg.top_speed   <= MAX_RESET;
            cfg_reg.floor_speed <= MIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KP_GAIN:     cfg_reg.kp_gain     <= cfg_wdata;
                REG_KI_GAIN:     cfg_reg.ki_gain     <= cfg_wdata;
                REG_KD_GAIN:     cfg_reg.kd_gain     <= cfg_wdata;
                REG_TOP_SPEED:   cfg_reg.top_speed   <= cfg_wdata;
                REG_FLOOR_SPEED: cfg_reg.floor_speed <= cfg_wdata;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Front end: decodes the sample and classifies it into a command item.
    logic  push_valid;
    logic  push_ready;
    item_t push_item;

    lfpd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sensor_bits (s_sensor_bits),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    // Queue that decouples the front from the back.
    logic  pop_valid;
    logic  pop_en;
    item_t pop_item;

    lfpd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_en     (pop_en),
        .pop_item   (pop_item)
    );

    // Back end: PID step, duty law and the output register.
    lfpd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_valid         (pop_valid),
        .q_pop           (pop_en),
        .q_item          (pop_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_left_duty     (m_left_duty),
        .m_right_duty    (m_right_duty),
        .m_left_reverse  (m_left_reverse),
        .m_right_reverse (m_right_reverse),
        .m_line_lost     (m_line_lost),
        .m_line_position (m_line_position)
    );

endmodule

FILE: rtl/core/lfpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_front: sensor decode and item classification
// Decodes each sensor sample, keeps the line position and the wheel
// direction bits, and issues a PID or a recovery-turn command item.
// ----------------------------------------------------------------------------
module lfpd_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lfpd_pkg::SENSOR_W-1:0]   s_sensor_bits,
    output logic                            push_valid,
    input  logic                            push_ready,
    output lfpd_pkg::item_t                 push_item
);
    import lfpd_pkg::*;

    localparam logic [SENSOR_W-1:0] ALL_DARK = 8'hFF;

    logic [POS_W-1:0] position_reg, position_next;
    logic             left_rev_reg, left_rev_next;
    logic             right_rev_reg, right_rev_next;
    logic             hit;
    logic [POS_W-1:0] dec_pos;
    logic             all_dark;
    logic             pos_neg;
    logic             pos_pos;
    cmd_t             cmd;

    always_comb begin
        hit     = 1'b1;
        dec_pos = '0;
        unique case (s_sensor_bits)
            8'hFE:        dec_pos = 4'(-7);
            8'hF8, 8'hFC: dec_pos = 4'(-6);
            8'hFD:        dec_pos = 4'(-5);
            8'hF1, 8'hF9: dec_pos = 4'(-4);
            8'hFB:        dec_pos = 4'(-3);
            8'hE3, 8'hF3: dec_pos = 4'(-2);
            8'hF7:        dec_pos = 4'(-1);
            8'hE7:        dec_pos = 4'd0;
            8'hEF:        dec_pos = 4'd1;
            8'hC7, 8'hCF: dec_pos = 4'd2;
            8'hDF:        dec_pos = 4'd3;
            8'h8F, 8'h9F: dec_pos = 4'd4;
            8'hBF:        dec_pos = 4'd5;
            8'h1F, 8'h3F: dec_pos = 4'd6;
            8'h7F:        dec_pos = 4'd7;
            default:      hit = 1'b0;
        endcase
    end

    // The all-dark sample never decodes, so the stored position decides the turn.
    assign all_dark = (s_sensor_bits == ALL_DARK);
    assign pos_neg  = position_reg[POS_W-1];
    assign pos_pos  = !position_reg[POS_W-1] && (position_reg != '0);

    always_comb begin
        position_next  = hit ? dec_pos : position_reg;
        left_rev_next  = hit ? 1'b0 : left_rev_reg;
        right_rev_next = hit ? 1'b0 : right_rev_reg;
        cmd            = CMD_PID;
        if (all_dark && pos_neg) begin
            cmd           = CMD_LOST_LEFT;
            left_rev_next = 1'b1;
        end else if (all_dark && pos_pos) begin
            cmd            = CMD_LOST_RIGHT;
            right_rev_next = 1'b1;
        end
    end

    assign push_valid          = s_valid;
    assign s_ready             = push_ready;
    assign push_item.cmd       = cmd;
    assign push_item.position  = position_next;
    assign push_item.left_rev  = left_rev_next;
    assign push_item.right_rev = right_rev_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= '0;
            left_rev_reg  <= 1'b0;
            right_rev_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            position_reg  <= position_next;
            left_rev_reg  <= left_rev_next;
            right_rev_reg <= right_rev_next;
        end
    end

endmodule

FILE: rtl/core/lfpd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_queue: command queue between front and back
// A small first-in first-out buffer of command items.
// ----------------------------------------------------------------------------
module lfpd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  lfpd_pkg::item_t  push_item,
    output logic             pop_valid,
    input  logic             pop_en,
    output lfpd_pkg::item_t  pop_item
);
    import lfpd_pkg::*;

    item_t               entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_en && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/lfpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_back: PID step and duty computation
// Sequences one command at a time: a PID command through the gain products,
// a shared divide-by-ten unit, the step products and the duty clamp.
// ----------------------------------------------------------------------------
module lfpd_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lfpd_pkg::cfg_t                        cfg,
    input  logic                                  q_valid,
    output logic                                  q_pop,
    input  lfpd_pkg::item_t                       q_item,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [lfpd_pkg::DUTY_W-1:0]    m_left_duty,
    output logic signed [lfpd_pkg::DUTY_W-1:0]    m_right_duty,
    output logic                                  m_left_reverse,
    output logic                                  m_right_reverse,
    output logic                                  m_line_lost,
    output logic signed [lfpd_pkg::POS_W-1:0]     m_line_position
);
    import lfpd_pkg::*;

    // Signed divide by ten, truncating toward zero, by reciprocal multiply.
    function automatic logic signed [ACC_W-1:0] div10_trunc(
        input logic signed [ACC_W-1:0] x
    );
        logic        neg;
        logic [16:0] mag;
        logic [32:0] prod;
        logic [15:0] q;
        neg  = x[ACC_W-1];
        mag  = neg ? (17'd0 - {x[ACC_W-1], x}) : {1'b0, x};
        prod = 33'(mag) * 33'(DIV10_RECIP);
        q    = 16'(prod[32:DIV10_SHIFT]);
        return neg ? signed'(16'd0 - q) : signed'(q);
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp_duty(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] lo,
        input logic signed [ACC_W-1:0] hi
    );
        logic signed [ACC_W-1:0] t;
        t = (v < lo) ? lo : v;
        return (t > hi) ? hi : t;
    endfunction

    back_state_t state_reg, state_next;
    logic        load_item;
    logic        out_load;
    logic        out_free;

    item_t                   item_reg;
    logic signed [ACC_W-1:0] integral_reg;
    logic signed [POS_W-1:0] prev_error_reg;
    logic signed [11:0]      p_raw_reg;
    logic signed [12:0]      d_raw_reg;
    logic signed [ACC_W-1:0] iprod_reg;
    logic signed [ACC_W-1:0] mv_reg, mv_next;
    logic signed [ACC_W-1:0] prod_a_reg;
    logic signed [ACC_W-1:0] prod_b_reg;
    logic                    m_valid_reg;

    logic signed [DUTY_W-1:0] left_duty_reg, left_duty_next;
    logic signed [DUTY_W-1:0] right_duty_reg, right_duty_next;
    logic                     left_rev_reg, right_rev_reg, lost_reg;
    logic signed [POS_W-1:0]  position_reg;

    // Products of the PID step.
    logic signed [ERR_W-1:0] err;
    logic signed [8:0]       kp_s, ki_s, kd_s;
    logic signed [13:0]      p_full;
    logic signed [ACC_W-1:0] isum;
    logic signed [24:0]      i_full;
    logic signed [5:0]       err_diff;
    logic signed [14:0]      d_full;

    // Shared divider.
    logic signed [ACC_W-1:0] div_in;
    logic signed [ACC_W-1:0] div_q;

    // Step products.
    logic signed [8:0]  speed_diff;
    logic signed [8:0]  speed_adj;
    logic signed [5:0]  step;
    logic signed [6:0]  step_m20;
    logic signed [22:0] a_full;
    logic signed [21:0] b_full;

    // Duty law.
    logic signed [ACC_W-1:0] ceil_s, floor_s, l16, r16;

    // ---------------- sequencer ----------------
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = (q_item.cmd == CMD_PID) ? BK_PROD : BK_DUTY;
                end
            end
            BK_PROD:  state_next = BK_DIV_I;
            BK_DIV_I: state_next = BK_DIV_P;
            BK_DIV_P: state_next = BK_DIV_D;
            BK_DIV_D: state_next = BK_MUL;
            BK_MUL:   state_next = BK_DUTY;
            BK_DUTY: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        load_item = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            BK_IDLE: load_item = q_valid;
            BK_DUTY: out_load  = out_free;
            default: begin
                load_item = 1'b0;
                out_load  = 1'b0;
            end
        endcase
    end

    assign q_pop = load_item;

    // ---------------- PID products ----------------
    assign err      = -signed'({item_reg.position[POS_W-1], item_reg.position});
    assign kp_s     = signed'({1'b0, cfg.kp_gain});
    assign ki_s     = signed'({1'b0, cfg.ki_gain});
    assign kd_s     = signed'({1'b0, cfg.kd_gain});
    assign p_full   = kp_s * err;
    assign isum     = integral_reg + ACC_W'(err);
    assign i_full   = isum * ki_s;
    assign err_diff = 6'(err) - 6'(prev_error_reg);
    assign d_full   = err_diff * kd_s;

    // ---------------- divide by ten ----------------
    always_comb begin
        case (state_reg)
            BK_DIV_P: div_in = ACC_W'(p_raw_reg);
            BK_DIV_D: div_in = ACC_W'(d_raw_reg);
            default:  div_in = iprod_reg;
        endcase
    end

    assign div_q   = div10_trunc(div_in);
    assign mv_next = (state_reg == BK_DIV_I) ? div_q : mv_reg + div_q;

    // ---------------- step products ----------------
    assign speed_diff = signed'({1'b0, cfg.top_speed}) - signed'({1'b0, cfg.floor_speed});
    // Rounds a negative difference toward zero before the shift.
    assign speed_adj  = speed_diff + (speed_diff[8] ? 9'sd7 : 9'sd0);
    assign step       = speed_adj[8:3];
    assign step_m20   = 7'(step) - STEP_BIAS;
    assign a_full     = step_m20 * mv_reg;
    assign b_full     = step * mv_reg;

    // ---------------- duty law ----------------
    assign ceil_s  = signed'(ACC_W'(cfg.top_speed) + 16'd1);
    assign floor_s = signed'(ACC_W'(cfg.floor_speed));

    always_comb begin
        if (mv_reg == '0) begin
            l16 = ceil_s - LEFT_TRIM;
            r16 = ceil_s;
        end else if (!mv_reg[ACC_W-1]) begin
            r16 = clamp_duty(ceil_s - prod_a_reg, floor_s, ceil_s);
            l16 = clamp_duty(ceil_s - prod_b_reg - TURN_BIAS - LEFT_TRIM, floor_s, ceil_s);
        end else begin
            l16 = clamp_duty(ceil_s + prod_a_reg, floor_s, ceil_s);
            r16 = clamp_duty(ceil_s + prod_b_reg - TURN_BIAS, floor_s, ceil_s);
        end
    end

    always_comb begin
        case (item_reg.cmd)
            CMD_LOST_LEFT: begin
                left_duty_next  = LOST_LEFT_LDUTY;
                right_duty_next = LOST_LEFT_RDUTY;
            end
            CMD_LOST_RIGHT: begin
                left_duty_next  = LOST_RIGHT_LDUTY;
                right_duty_next = LOST_RIGHT_RDUTY;
            end
            default: begin
                left_duty_next  = l16[DUTY_W-1:0];
                right_duty_next = r16[DUTY_W-1:0];
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            m_valid_reg    <= 1'b0;
            integral_reg   <= '0;
            prev_error_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == BK_PROD) begin
                prev_error_reg <= err[POS_W-1:0];
            end
            if (state_reg == BK_DIV_I) begin
                integral_reg <= div_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_item) begin
            item_reg <= q_item;
        end
        if (state_reg == BK_PROD) begin
            p_raw_reg <= p_full[11:0];
            d_raw_reg <= d_full[12:0];
            iprod_reg <= i_full[ACC_W-1:0];
        end
        if (state_reg == BK_DIV_I || state_reg == BK_DIV_P || state_reg == BK_DIV_D) begin
            mv_reg <= mv_next;
        end
        if (state_reg == BK_MUL) begin
            prod_a_reg <= a_full[ACC_W-1:0];
            prod_b_reg <= b_full[ACC_W-1:0];
        end
        if (out_load) begin
            left_duty_reg  <= left_duty_next;
            right_duty_reg <= right_duty_next;
            left_rev_reg   <= item_reg.left_rev;
            right_rev_reg  <= item_reg.right_rev;
            lost_reg       <= (item_reg.cmd != CMD_PID);
            position_reg   <= signed'(item_reg.position);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_left_duty     = left_duty_reg;
    assign m_right_duty    = right_duty_reg;
    assign m_left_reverse  = left_rev_reg;
    assign m_right_reverse = right_rev_reg;
    assign m_line_lost     = lost_reg;
    assign m_line_position = position_reg;

endmodule

FILE: tb/lfpd_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_drive_checker: drive result checker for the line-follow PID drive
// Tracks register writes and sensor items taken by the block, computes the
// drive result each item must produce and compares it with what comes out.
// ----------------------------------------------------------------------------
module lfpd_drive_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lfpd_pkg::GAIN_W-1:0]        cfg_wdata,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [lfpd_pkg::SENSOR_W-1:0]      s_sensor_bits,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [lfpd_pkg::DUTY_W-1:0] m_left_duty,
    input  logic signed [lfpd_pkg::DUTY_W-1:0] m_right_duty,
    input  logic                               m_left_reverse,
    input  logic                               m_right_reverse,
    input  logic                               m_line_lost,
    input  logic signed [lfpd_pkg::POS_W-1:0]  m_line_position,
    output int                                 mismatch_count,
    output int                                 results_pending
);
    import lfpd_pkg::*;

    // Fixed duties of the recovery turns and the drive law offsets.
    localparam int TURN_LEFT_LDUTY  = 150;
    localparam int TURN_LEFT_RDUTY  = 185;
    localparam int TURN_RIGHT_LDUTY = 180;
    localparam int TURN_RIGHT_RDUTY = 155;
    localparam int TRIM             = 5;
    localparam int BIAS             = 15;
    localparam int STEP_OFFSET      = 20;
    localparam logic [SENSOR_W-1:0] ALL_DARK = 8'hFF;

    typedef struct packed {
        logic signed [DUTY_W-1:0] left_duty;
        logic signed [DUTY_W-1:0] right_duty;
        logic                     left_reverse;
        logic                     right_reverse;
        logic                     line_lost;
        logic signed [POS_W-1:0]  line_position;
    } drive_result_t;

    drive_result_t expected_drive[$];
    drive_result_t head_drive;

    cfg_t gains;
    int   line_pos;
    int   integ_acc;
    int   last_err;
    logic left_back;
    logic right_back;

    function automatic int wrap16(input int x);
        logic signed [15:0] low;
        low = x[15:0];
        return int'(low);
    endfunction

    function automatic int clamp_duty(input int v, input int lo, input int hi);
        int r;
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    // Maps a sensor pattern to a line position; returns 0 for unknown ones.
    function automatic bit decode_line(input logic [SENSOR_W-1:0] s, output int pos);
        bit hit;
        hit = 1'b1;
        pos = 0;
        case (s)
            8'hFE:        pos = -7;
            8'hF8, 8'hFC: pos = -6;
            8'hFD:        pos = -5;
            8'hF1, 8'hF9: pos = -4;
            8'hFB:        pos = -3;
            8'hE3, 8'hF3: pos = -2;
            8'hF7:        pos = -1;
            8'hE7:        pos = 0;
            8'hEF:        pos = 1;
            8'hC7, 8'hCF: pos = 2;
            8'hDF:        pos = 3;
            8'h8F, 8'h9F: pos = 4;
            8'hBF:        pos = 5;
            8'h1F, 8'h3F: pos = 6;
            8'h7F:        pos = 7;
            default:      hit = 1'b0;
        endcase
        return hit;
    endfunction

    task automatic predict_drive(input logic [SENSOR_W-1:0] sample);
        int ceil_duty, floor_duty, step, lduty, rduty, decoded;
        int err, p_term, d_term, mv;
        logic lost;
        drive_result_t r;
        ceil_duty  = int'(gains.top_speed) + 1;
        floor_duty = int'(gains.floor_speed);
        step       = (int'(gains.top_speed) - int'(gains.floor_speed)) / 8;
        lost       = 1'b0;
        if (decode_line(sample, decoded)) begin
            line_pos   = decoded;
            left_back  = 1'b0;
            right_back = 1'b0;
        end
        if (sample == ALL_DARK && line_pos < 0) begin
            lduty     = TURN_LEFT_LDUTY;
            rduty     = TURN_LEFT_RDUTY;
            left_back = 1'b1;
            lost      = 1'b1;
        end else if (sample == ALL_DARK && line_pos > 0) begin
            lduty      = TURN_RIGHT_LDUTY;
            rduty      = TURN_RIGHT_RDUTY;
            right_back = 1'b1;
            lost       = 1'b1;
        end else begin
            err       = -line_pos;
            p_term    = (int'(gains.kp_gain) * err) / 10;
            integ_acc = wrap16(integ_acc + err);
            integ_acc = wrap16(integ_acc * int'(gains.ki_gain)) / 10;
            d_term    = ((err - last_err) * int'(gains.kd_gain)) / 10;
            last_err  = err;
            mv        = wrap16(p_term + integ_acc + d_term);
            if (mv == 0) begin
                // No clamp here, so a small ceiling drives the left duty negative.
                lduty = ceil_duty - TRIM;
                rduty = ceil_duty;
            end else if (mv > 0) begin
                rduty = wrap16(ceil_duty - wrap16((step - STEP_OFFSET) * mv));
                lduty = wrap16(ceil_duty - wrap16(step * mv) - BIAS - TRIM);
                lduty = clamp_duty(lduty, floor_duty, ceil_duty);
                rduty = clamp_duty(rduty, floor_duty, ceil_duty);
            end else begin
                lduty = wrap16(ceil_duty + wrap16((step - STEP_OFFSET) * mv));
                rduty = wrap16(ceil_duty + wrap16(wrap16(step * mv) - BIAS));
                lduty = clamp_duty(lduty, floor_duty, ceil_duty);
                rduty = clamp_duty(rduty, floor_duty, ceil_duty);
            end
        end
        r.left_duty     = lduty[DUTY_W-1:0];
        r.right_duty    = rduty[DUTY_W-1:0];
        r.left_reverse  = left_back;
        r.right_reverse = right_back;
        r.line_lost     = lost;
        r.line_position = line_pos[POS_W-1:0];
        expected_drive.push_back(r);
    endtask

    task automatic check_field(input string name, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            gains.kp_gain     = 8'd10;
            gains.ki_gain     = 8'd0;
            gains.kd_gain     = 8'd5;
            gains.top_speed   = 8'd255;
            gains.floor_speed = 8'd0;
            line_pos          = 0;
            integ_acc         = 0;
            last_err          = 0;
            left_back         = 1'b0;
            right_back        = 1'b0;
            expected_drive.delete();
            mismatch_count    = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_KP_GAIN:     gains.kp_gain     = cfg_wdata;
                    REG_KI_GAIN:     gains.ki_gain     = cfg_wdata;
                    REG_KD_GAIN:     gains.kd_gain     = cfg_wdata;
                    REG_TOP_SPEED:   gains.top_speed   = cfg_wdata;
                    REG_FLOOR_SPEED: gains.floor_speed = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_drive(s_sensor_bits);
            if (m_valid && m_ready) begin
                if (expected_drive.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual left %0d right %0d",
                             $time, m_left_duty, m_right_duty);
                    mismatch_count++;
                end else begin
                    head_drive = expected_drive.pop_front();
                    check_field("left_duty", head_drive.left_duty, m_left_duty);
                    check_field("right_duty", head_drive.right_duty, m_right_duty);
                    check_field("left_reverse", head_drive.left_reverse, m_left_reverse);
                    check_field("right_reverse", head_drive.right_reverse, m_right_reverse);
                    check_field("line_lost", head_drive.line_lost, m_line_lost);
                    check_field("line_position", head_drive.line_position, m_line_position);
                end
            end
        end
        results_pending = expected_drive.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top of the line-follow PID drive verification
// Resets the block, sends directed and random sensor items across a series
// of gain and speed settings, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;
    import lfpd_pkg::*;

    // Ten settings of about two hundred random items each.
    localparam int SETTING_COUNT   = 10;
    localparam int ITEMS_PER_SET   = 195;
    // The limit leaves plenty of room for long receiver stalls and sender gaps.
    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int PATTERN_COUNT   = 21;
    localparam logic [SENSOR_W-1:0] ALL_DARK = 8'hFF;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_CADENCE
    } ready_mode_t;

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index     = REG_KP_GAIN;
    logic [GAIN_W-1:0]           cfg_wdata     = '0;
    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic [SENSOR_W-1:0]         s_sensor_bits = '0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic signed [DUTY_W-1:0]    m_left_duty;
    logic signed [DUTY_W-1:0]    m_right_duty;
    logic                        m_left_reverse;
    logic                        m_right_reverse;
    logic                        m_line_lost;
    logic signed [POS_W-1:0]     m_line_position;

    int mismatch_count;
    int results_pending;
    int cycle_count  = 0;
    int drift_idx    = 11;
    int burst_left   = 0;

    ready_mode_t ready_mode = READY_ALWAYS;
    int          ready_hold = 0;
    int          ready_tick = 0;

    line_follow_pid_drive dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sensor_bits   (s_sensor_bits),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_left_duty     (m_left_duty),
        .m_right_duty    (m_right_duty),
        .m_left_reverse  (m_left_reverse),
        .m_right_reverse (m_right_reverse),
        .m_line_lost     (m_line_lost),
        .m_line_position (m_line_position)
    );

    lfpd_drive_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sensor_bits   (s_sensor_bits),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_left_duty     (m_left_duty),
        .m_right_duty    (m_right_duty),
        .m_left_reverse  (m_left_reverse),
        .m_right_reverse (m_right_reverse),
        .m_line_lost     (m_line_lost),
        .m_line_position (m_line_position),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always #5 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("line_follow_pid_drive test failed");
            $finish;
        end
    end

    // The receiver switches at random between several stall styles, so
    // back-pressure hits the block in every phase of its sequencer,
    // with long stretches of no stall at all in between.
    always @(negedge aclk) begin
        if (ready_hold == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_hold = $urandom_range(32, 256);
        end else begin
            ready_hold = ready_hold - 1;
        end
        ready_tick = ready_tick + 1;
        case (ready_mode)
            READY_ALWAYS:  m_ready <= 1'b1;
            READY_COIN:    m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:  m_ready <= ($urandom_range(0, 7) == 0);
            READY_CADENCE: m_ready <= (ready_tick % 5 != 4);
            default:       m_ready <= 1'b1;
        endcase
    end

    // All stimulus tasks start and end at a falling edge. An item is held
    // until the rising edge at which s_ready is seen high; the task then
    // returns at the next falling edge with s_valid still high, so the next
    // item follows back to back unless the caller drops valid first.
    task automatic send_sample(input logic [SENSOR_W-1:0] sample);
        s_sensor_bits <= sample;
        s_valid       <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic idle_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Waits until every expected result has come back, leaving the block idle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (results_pending != 0) @(negedge aclk);
    endtask

    // Writes every register, one per cycle.
    task automatic write_config(input cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_KP_GAIN;
        cfg_wdata <= c.kp_gain;
        @(negedge aclk);
        cfg_index <= REG_KI_GAIN;
        cfg_wdata <= c.ki_gain;
        @(negedge aclk);
        cfg_index <= REG_KD_GAIN;
        cfg_wdata <= c.kd_gain;
        @(negedge aclk);
        cfg_index <= REG_TOP_SPEED;
        cfg_wdata <= c.top_speed;
        @(negedge aclk);
        cfg_index <= REG_FLOOR_SPEED;
        cfg_wdata <= c.floor_speed;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Recognized sensor patterns, ordered from far left to far right.
    function automatic logic [SENSOR_W-1:0] line_pattern(input int k);
        case (k)
            0:  return 8'hFE;
            1:  return 8'hF8;
            2:  return 8'hFC;
            3:  return 8'hFD;
            4:  return 8'hF1;
            5:  return 8'hF9;
            6:  return 8'hFB;
            7:  return 8'hE3;
            8:  return 8'hF3;
            9:  return 8'hF7;
            10: return 8'hE7;
            11: return 8'hEF;
            12: return 8'hC7;
            13: return 8'hCF;
            14: return 8'hDF;
            15: return 8'h8F;
            16: return 8'h9F;
            17: return 8'hBF;
            18: return 8'h1F;
            19: return 8'h3F;
            default: return 8'h7F;
        endcase
    endfunction

    // Mostly a line that drifts smoothly under the sensors, with lost-line
    // samples and arbitrary noise mixed in so the recovery turns and the
    // hold-position path both get a real workout.
    function automatic logic [SENSOR_W-1:0] next_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            if (roll < 6) drift_idx = $urandom_range(0, PATTERN_COUNT - 1);
            else drift_idx = drift_idx + $urandom_range(0, 4) - 2;
            if (drift_idx < 0) drift_idx = 0;
            if (drift_idx > PATTERN_COUNT - 1) drift_idx = PATTERN_COUNT - 1;
            return line_pattern(drift_idx);
        end else if (roll < 78) begin
            return ALL_DARK;
        end else begin
            return 8'($urandom_range(0, 255));
        end
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.kp_gain     = 8'($urandom_range(0, 255));
        c.ki_gain     = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 20))
                                                    : 8'($urandom_range(0, 255));
        c.kd_gain     = 8'($urandom_range(0, 255));
        c.top_speed   = 8'($urandom_range(0, 255));
        // Now and then the floor lands above the ceiling.
        c.floor_speed = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, c.top_speed));
        return c;
    endfunction

    initial begin
        cfg_t setting;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed items under the reset settings: centered line with zero
        // controller output, lost line at center position, lost line on
        // either side, noise that must keep position and reverse bits, and
        // a sweep of recognized patterns including the two-sensor ones.
        send_sample(8'hE7);
        send_sample(8'hFF);
        send_sample(8'hFE);
        send_sample(8'hFF);
        send_sample(8'hFF);
        send_sample(8'hE7);
        send_sample(8'h7F);
        send_sample(8'hFF);
        send_sample(8'h00);
        send_sample(8'h55);
        send_sample(8'hAA);
        send_sample(8'hF8);
        send_sample(8'h3F);
        send_sample(8'hF7);
        send_sample(8'hEF);
        send_sample(8'h81);
        send_sample(8'hE7);

        // Each setting is written with the block idle, then followed by a
        // random run. The first few settings are the extremes: the reset
        // values, everything at full scale, the floor above the ceiling,
        // and everything at zero, which keeps the output at zero and the
        // left duty below zero.
        for (int set_no = 0; set_no < SETTING_COUNT; set_no++) begin
            drain_results();
            case (set_no)
                0:       setting = {8'd10, 8'd0, 8'd5, 8'd255, 8'd0};
                1:       setting = {8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
                2:       setting = {8'd255, 8'd0, 8'd0, 8'd0, 8'd255};
                3:       setting = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
                4:       setting = {8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
                default: setting = random_config();
            endcase
            write_config(setting);

            // The sender works in bursts: some continue straight into the
            // next one, others pause for a random number of cycles.
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 15));
                    burst_left = $urandom_range(1, 40);
                end
                send_sample(next_sample());
                burst_left--;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("line_follow_pid_drive test passed");
        end else begin
            $display("line_follow_pid_drive test failed");
        end
        $finish;
    end

endmodule
